@@ rtl/core/ssp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int ANGLE_W      = 9;
    localparam int PULSE_W      = 16;
    localparam int IVL_W        = 16;

    localparam logic [ANGLE_W-1:0] FULL_SCALE = 9'd360;

    localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 16'd488;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 16'd2557;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE = 1'd1;

    // Result queue; the depth must be a power of two.
    localparam int OUT_DEPTH = 8;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);
    localparam int USED_W    = $clog2(OUT_DEPTH + 6);

    // Division by the full scale through a reciprocal and one correction.
    localparam int TOT_W     = 26;
    localparam int DIV_SHIFT = 34;
    localparam int RECIP_W   = 26;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << DIV_SHIFT) / 64'd360);
    localparam int QUOT_W    = 17;

    typedef enum logic [1:0] {
        CMD_MOVE  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_ANGLE = 2'd2,
        CMD_RAW   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic [1:0]         channel;
        logic [ANGLE_W-1:0] target_half_deg;
        logic [IVL_W-1:0]   interval_ms;
        logic [PULSE_W-1:0] raw_pulse;
    } t_in;

    typedef struct packed {
        logic [1:0]         out_channel;
        logic [PULSE_W-1:0] pulse;
        logic               last;
    } t_out;

endpackage

`default_nettype wire

@@ rtl/core/ssp_pulse_map.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ssp_pulse_map (
    input  wire logic                         i_clk,
    input  wire logic [ssp_pkg::ANGLE_W-1:0]  i_angle,
    input  wire logic [ssp_pkg::PULSE_W-1:0]  i_min_pulse,
    input  wire logic [ssp_pkg::PULSE_W-1:0]  i_max_pulse,
    output logic      [ssp_pkg::PULSE_W-1:0]  o_pulse
);
    import ssp_pkg::*;

    // Three stages: min*360 + angle*span, then the reciprocal product, then correction.
    logic signed [PULSE_W:0]   span;
    logic signed [27:0]        total;
    logic        [TOT_W-1:0]   r_tot;
    logic        [TOT_W-1:0]   r_tot2;
    logic        [QUOT_W-1:0]  r_q0;
    logic        [TOT_W+RECIP_W-1:0] prod;
    logic        [TOT_W:0]     rem;
    logic        [QUOT_W-1:0]  quot;
    logic        [PULSE_W-1:0] r_pulse;

    always_comb begin
        span  = $signed({1'b0, i_max_pulse}) - $signed({1'b0, i_min_pulse});
        total = 28'($signed({1'b0, i_min_pulse}) * $signed({1'b0, FULL_SCALE}))
              + 28'($signed({1'b0, i_angle}) * span);
        prod  = r_tot * RECIP;
        rem   = {1'b0, r_tot2} - (TOT_W+1)'(r_q0 * FULL_SCALE);
        quot  = (rem >= (TOT_W+1)'(FULL_SCALE)) ? r_q0 + 1'b1 : r_q0;
    end

    always_ff @(posedge i_clk) begin
        r_tot   <= total[27] ? '0 : total[TOT_W-1:0];
        r_q0    <= prod[DIV_SHIFT +: QUOT_W];
        r_tot2  <= r_tot;
        r_pulse <= quot[PULSE_W-1:0];
    end

    assign o_pulse = r_pulse;

endmodule

`default_nettype wire

@@ rtl/core/servo_slew_pulse_generator.sv @@
// Four-channel servo compare-value generator with slew limiting per channel.
// Input channel (i_valid/o_ready, i_data): move, tick, set-angle and raw-pulse
// commands. Output channel (o_valid/i_ready, o_data): compare values with the
// channel number; last marks the final result of an item, and an item may give
// none, one or, for a tick, up to one result per channel in channel order.
// Configuration: i_cfg_we writes min_pulse (index 0) or max_pulse (index 1) at
// once; write only while the block is idle.
// A command visits the state memory once; a tick visits every channel in turn,
// as each channel state is read, updated and written back. Other commands may
// be taken back to back while the queue has room; intake halts while a tick
// walks the channels. A result passes the state read, the pulse map and a
// holding register; the final result of an item waits until the item's last
// channel has been visited so that its last flag is known.
// The result queue holds eight entries; o_ready falls when it may fill, so a
// stalled receiver loses nothing and halts intake.
// Reset clears the channel states to angle zero, target zero, interval one,
// registers to 488 and 2557, and empties the pipeline and queue; o_ready is
// high in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module servo_slew_pulse_generator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire ssp_pkg::t_in                    i_data,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output ssp_pkg::t_out                        o_data,
    input  wire logic                            i_cfg_we,
    input  wire logic [ssp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [ssp_pkg::PULSE_W-1:0]     i_cfg_data
);
    import ssp_pkg::*;

    typedef struct packed {
        logic [ANGLE_W-1:0] cur;
        logic [ANGLE_W-1:0] tgt;
        logic [IVL_W-1:0]   ivl;
        logic [IVL_W-1:0]   cnt;
    } t_chan_st;

    typedef struct packed {
        t_cmd               cmd;
        logic [CH_W-1:0]    ch;
        logic               fin;
        logic [ANGLE_W-1:0] tgt;
        logic [IVL_W-1:0]   ivl;
        logic [PULSE_W-1:0] raw;
    } t_tok;

    typedef struct packed {
        logic               emit;
        logic               fin;
        logic               raw_sel;
        logic [CH_W-1:0]    ch;
        logic [PULSE_W-1:0] raw;
    } t_side;

    localparam t_chan_st ST_RST = '{cur: '0, tgt: '0, ivl: IVL_W'(1), cnt: '0};

    function automatic t_chan_st step_toward(t_chan_st s);
        t_chan_st r;
        r = s;
        if (s.cur < s.tgt) begin
            r.cur = s.cur + 1'b1;
        end else begin
            r.cur = s.cur - 1'b1;
        end
        r.cnt = (r.cur == s.tgt) ? '0 : s.ivl;
        return r;
    endfunction

    logic [PULSE_W-1:0] r_min_pulse;
    logic [PULSE_W-1:0] r_max_pulse;

    t_chan_st r_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_st_vld;
    t_chan_st r_mem_q;
    logic     r_mem_q_vld;

    logic            r_tick_busy;
    logic [CH_W-1:0] r_vis;

    logic  r_rd_vld;
    t_tok  r_rd;
    t_tok  n_rd;
    logic  issue;
    logic  [CH_W-1:0] issue_addr;

    logic            r_fwd_vld;
    logic [CH_W-1:0] r_fwd_ch;
    t_chan_st        r_fwd_st;

    t_chan_st st;
    t_chan_st n_st;
    logic     wr;
    logic     emit;
    logic [ANGLE_W-1:0] angle;
    logic [ANGLE_W-1:0] in_tgt;
    logic [IVL_W-1:0]   in_ivl;

    logic [2:0] r_sb_vld;
    t_side      r_sb [3];
    logic [PULSE_W-1:0] map_pulse;
    logic [PULSE_W-1:0] tok_pulse;

    logic               r_p_vld;
    logic               r_p_done;
    logic [CH_W-1:0]    r_p_ch;
    logic [PULSE_W-1:0] r_p_pulse;
    logic               push;
    logic               push_last;

    t_out              r_fifo [OUT_DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [CNT_W-1:0]  r_cnt;
    logic              pop;
    logic [USED_W-1:0] used;
    logic              can_issue;
    logic              acc;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_pulse <= MIN_PULSE_RST;
            r_max_pulse <= MAX_PULSE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MIN_PULSE: r_min_pulse <= i_cfg_data;
                REG_MAX_PULSE: r_max_pulse <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Issue: credits cover every token that may still reach the result queue.
    always_comb begin
        used = USED_W'(r_cnt) + USED_W'(r_rd_vld) + USED_W'($countones(r_sb_vld))
             + USED_W'(r_p_vld);
        can_issue = (used < USED_W'(OUT_DEPTH));
        o_ready   = !r_tick_busy && can_issue;
        acc       = i_valid && o_ready;
        in_tgt    = (i_data.target_half_deg > FULL_SCALE) ? FULL_SCALE
                                                          : i_data.target_half_deg;
        in_ivl    = (i_data.interval_ms == '0) ? IVL_W'(1) : i_data.interval_ms;
        n_rd      = '{cmd: i_data.cmd, ch: CH_W'(i_data.channel), fin: 1'b1,
                      tgt: in_tgt, ivl: in_ivl, raw: i_data.raw_pulse};
        issue     = 1'b0;
        if (r_tick_busy) begin
            issue      = can_issue;
            n_rd.cmd   = CMD_TICK;
            n_rd.ch    = r_vis;
            n_rd.fin   = (r_vis == CH_W'(NUM_CHANNELS - 1));
        end else if (acc) begin
            if (i_data.cmd == CMD_TICK) begin
                issue    = 1'b1;
                n_rd.ch  = '0;
                n_rd.fin = (NUM_CHANNELS == 1);
            end else begin
                issue = (int'(i_data.channel) < NUM_CHANNELS);
            end
        end
        issue_addr = n_rd.ch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_busy <= 1'b0;
            r_vis       <= '0;
            r_rd_vld    <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            if (r_tick_busy) begin
                if (can_issue) begin
                    if (n_rd.fin) begin
                        r_tick_busy <= 1'b0;
                    end else begin
                        r_vis <= r_vis + 1'b1;
                    end
                end
            end else if (acc && i_data.cmd == CMD_TICK && NUM_CHANNELS > 1) begin
                r_tick_busy <= 1'b1;
                r_vis       <= CH_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= n_rd;
    end

    // Channel state memory: one read and one write each cycle.
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_rd.ch] <= n_st;
        end
        r_mem_q <= r_mem[issue_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_vld    <= '0;
            r_mem_q_vld <= 1'b0;
            r_fwd_vld   <= 1'b0;
        end else begin
            if (wr) begin
                r_st_vld[r_rd.ch] <= 1'b1;
            end
            r_mem_q_vld <= r_st_vld[issue_addr];
            r_fwd_vld   <= wr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_ch <= r_rd.ch;
        r_fwd_st <= n_st;
    end

    // Read-modify-write of one channel; the previous write is forwarded.
    always_comb begin
        if (r_fwd_vld && r_fwd_ch == r_rd.ch) begin
            st = r_fwd_st;
        end else if (r_mem_q_vld) begin
            st = r_mem_q;
        end else begin
            st = ST_RST;
        end
        n_st  = st;
        wr    = 1'b0;
        emit  = 1'b0;
        angle = st.cur;
        if (r_rd_vld) begin
            case (r_rd.cmd)
                CMD_MOVE: begin
                    wr      = 1'b1;
                    n_st.tgt = r_rd.tgt;
                    n_st.ivl = r_rd.ivl;
                    if (st.cur == r_rd.tgt) begin
                        n_st.cnt = '0;
                    end else begin
                        n_st  = step_toward(n_st);
                        emit  = 1'b1;
                        angle = n_st.cur;
                    end
                end
                CMD_TICK: begin
                    wr = 1'b1;
                    if (st.cur != st.tgt) begin
                        if (st.cnt > IVL_W'(1)) begin
                            n_st.cnt = st.cnt - 1'b1;
                        end else begin
                            n_st  = step_toward(st);
                            emit  = 1'b1;
                            angle = n_st.cur;
                        end
                    end
                end
                CMD_ANGLE: begin
                    emit  = 1'b1;
                    angle = r_rd.tgt;
                end
                CMD_RAW: begin
                    emit = 1'b1;
                end
                default: ;
            endcase
        end
    end

    ssp_pulse_map u_map (
        .i_clk       (i_clk),
        .i_angle     (angle),
        .i_min_pulse (r_min_pulse),
        .i_max_pulse (r_max_pulse),
        .o_pulse     (map_pulse)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb_vld <= '0;
        end else begin
            r_sb_vld <= {r_sb_vld[1:0], r_rd_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sb[0] <= '{emit: emit, fin: r_rd.fin, raw_sel: (r_rd.cmd == CMD_RAW),
                     ch: r_rd.ch, raw: r_rd.raw};
        r_sb[1] <= r_sb[0];
        r_sb[2] <= r_sb[1];
    end

    // The newest result of an item waits here until it is known whether it is the last.
    always_comb begin
        tok_pulse = r_sb[2].raw_sel ? r_sb[2].raw : map_pulse;
        push      = r_p_vld && ((r_sb_vld[2] && (r_sb[2].emit || r_sb[2].fin)) || r_p_done);
        push_last = r_p_done || (r_sb_vld[2] && !r_sb[2].emit && r_sb[2].fin);
        pop       = o_valid && i_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld  <= 1'b0;
            r_p_done <= 1'b0;
        end else if (r_sb_vld[2] && r_sb[2].emit) begin
            r_p_vld  <= 1'b1;
            r_p_done <= r_sb[2].fin;
        end else if (push) begin
            r_p_vld  <= 1'b0;
            r_p_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sb_vld[2] && r_sb[2].emit) begin
            r_p_ch    <= r_sb[2].ch;
            r_p_pulse <= tok_pulse;
        end
        if (push) begin
            r_fifo[r_wp] <= '{out_channel: 2'(r_p_ch), pulse: r_p_pulse, last: push_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: ;
            endcase
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_fifo[r_rp];

endmodule

`default_nettype wire

@@ rtl/core/ssp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ssp_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire logic                           o_ready,
    input  wire ssp_pkg::t_in                   i_data,
    input  wire logic                           o_valid,
    input  wire logic                           i_ready,
    input  wire ssp_pkg::t_out                  o_data
);
    import ssp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result item changed or vanished while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result item present after reset");

    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready)
        else $error("input not ready after reset");

    a_tick_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_data.cmd == CMD_TICK |=> !o_ready)
        else $error("input taken while a tick walks the channels");

endmodule

bind servo_slew_pulse_generator ssp_checker u_ssp_checker (.*);

`default_nettype wire
